>>> rtl/radix_digit_expander_assert.svh
// assertion macros used by the top-level rtl file
`ifndef RADIX_DIGIT_EXPANDER_ASSERT_SVH
`define RADIX_DIGIT_EXPANDER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// property checked on every rising clock edge outside reset
`define RDE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// same-cycle implication
`define RDE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);
`else
`define RDE_ASSERT(lbl, prop, msg)
`define RDE_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/rde_pkg.sv
package rde_pkg;

  // block limits
  localparam int MaxDigits = 16;
  localparam int MaxBase   = 16;

  // field and port widths
  localparam int CodeW   = 63;
  localparam int DigitW  = 4;
  localparam int PosW    = 4;
  localparam int CfgW    = 5;
  localparam int CfgIdxW = 4;

  // internal widths: place power up to 16^15, its triple, and base^count up to 16^16
  localparam int PowW   = 61;
  localparam int TriW   = PowW + 1;
  localparam int TotalW = 65;
  localparam int RemW   = CodeW + 1;
  localparam int IdxW   = $clog2(MaxDigits);
  localparam int CntW   = $clog2(MaxDigits + 1);
  localparam int RedCntW = $clog2(CodeW);

  // queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // register indexes
  localparam logic [CfgIdxW-1:0] RegDigitBase  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegDigitCount = CfgIdxW'(1);

  // register reset values
  localparam logic [CfgW-1:0] BaseReset  = CfgW'(2);
  localparam logic [CfgW-1:0] CountReset = CfgW'(16);

  // one row of the place power table
  typedef struct packed {
    logic [PowW-1:0] pw;
    logic [TriW-1:0] trip;
  } pow_entry_t;

  // status of the power table towards front and back
  typedef struct packed {
    logic              ready;
    logic [TotalW-1:0] total;
    logic [IdxW-1:0]   last_idx;
  } pwr_stat_t;

  // word passed from front to back
  typedef struct packed {
    logic [CodeW-1:0] code;
    logic             err;
  } work_t;

  typedef enum logic [1:0] {
    FrIdle,
    FrReduce,
    FrPush
  } front_state_e;

  typedef enum logic [1:0] {
    BkIdle,
    BkHigh,
    BkLow
  } back_state_e;

endpackage

>>> rtl/rde_power.sv
module rde_power (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_we_i,
  input  logic [rde_pkg::CfgIdxW-1:0]                 cfg_index_i,
  input  logic [rde_pkg::CfgW-1:0]                    cfg_data_i,
  output rde_pkg::pow_entry_t [rde_pkg::MaxDigits-1:0] pow_tab_o,
  output rde_pkg::pwr_stat_t                          stat_o
);
  import rde_pkg::*;

  logic [CfgW-1:0]        base_q;
  logic [CfgW-1:0]        count_q;
  logic [CfgW-1:0]        eff_base;
  logic [CntW-1:0]        eff_count;
  logic                   busy_q;
  logic [CntW-1:0]        step_q;
  logic [TotalW-1:0]      pw_q;
  logic [TotalW-1:0]      pw_d;
  logic [TotalW-1:0]      total_q;
  logic [TotalW+CfgW-1:0] prod;
  logic [TriW-1:0]        trip;
  logic                   tab_we;
  pow_entry_t [MaxDigits-1:0] tab_q;

  // clamp the registers into their meaningful range
  always_comb begin
    if (base_q < CfgW'(2)) begin
      eff_base = CfgW'(2);
    end else if (base_q > CfgW'(MaxBase)) begin
      eff_base = CfgW'(MaxBase);
    end else begin
      eff_base = base_q;
    end
    if (count_q == '0) begin
      eff_count = CntW'(1);
    end else if (count_q > CfgW'(MaxDigits)) begin
      eff_count = CntW'(MaxDigits);
    end else begin
      eff_count = CntW'(count_q);
    end
  end

  // next power, and the triple of the current power
  assign prod   = (TotalW+CfgW)'(pw_q) * (TotalW+CfgW)'(eff_base);
  assign pw_d   = prod[TotalW-1:0];
  assign trip   = TriW'(pw_q[PowW-1:0]) + {pw_q[PowW-1:0], 1'b0};
  assign tab_we = busy_q && !cfg_we_i && (step_q < eff_count);

  // registers and power sequencer, restarted by every write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= BaseReset;
      count_q <= CountReset;
      busy_q  <= 1'b1;
      step_q  <= '0;
      pw_q    <= TotalW'(1);
      total_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == RegDigitBase) begin
        base_q <= cfg_data_i;
      end
      if (cfg_index_i == RegDigitCount) begin
        count_q <= cfg_data_i;
      end
      busy_q <= 1'b1;
      step_q <= '0;
      pw_q   <= TotalW'(1);
    end else if (busy_q) begin
      if (step_q == eff_count) begin
        total_q <= pw_q;
        busy_q  <= 1'b0;
      end else begin
        pw_q   <= pw_d;
        step_q <= step_q + CntW'(1);
      end
    end
  end

  // table rows, base^k at row k
  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_q[step_q[IdxW-1:0]] <= '{pw: pw_q[PowW-1:0], trip: trip};
    end
  end

  assign pow_tab_o       = tab_q;
  assign stat_o.ready    = !busy_q;
  assign stat_o.total    = total_q;
  assign stat_o.last_idx = IdxW'(eff_count - CntW'(1));

endmodule

>>> rtl/rde_front.sv
module rde_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [rde_pkg::CodeW-1:0]  code_i,
  input  rde_pkg::pwr_stat_t         stat_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output rde_pkg::work_t             q_data_o
);
  import rde_pkg::*;

  front_state_e       state_q;
  front_state_e       state_d;
  logic [RedCntW-1:0] cnt_q;
  logic [CodeW-1:0]   code_q;
  logic [RemW-1:0]    rem_q;
  logic [RemW-1:0]    shifted;
  logic [RemW-1:0]    rem_d;
  logic               accept;
  logic               code_ge;
  logic               last_step;

  // range check of the incoming word
  assign accept    = in_valid_i && in_ready_o;
  assign code_ge   = TotalW'(code_i) >= stat_i.total;
  assign last_step = cnt_q == RedCntW'(CodeW - 1);

  // one remainder bit a cycle, code bits taken msb first
  always_comb begin
    shifted = {rem_q[RemW-2:0], code_q[CodeW-1]};
    if (TotalW'(shifted) >= stat_i.total) begin
      rem_d = shifted - stat_i.total[RemW-1:0];
    end else begin
      rem_d = shifted;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FrIdle: begin
        if (accept && code_ge) begin
          state_d = FrReduce;
        end
      end
      FrReduce: begin
        if (last_step) begin
          state_d = FrPush;
        end
      end
      FrPush: begin
        if (!q_full_i) begin
          state_d = FrIdle;
        end
      end
      default: state_d = FrIdle;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    q_push_o   = 1'b0;
    q_data_o   = '{code: code_i, err: 1'b0};
    unique case (state_q)
      FrIdle: begin
        in_ready_o = stat_i.ready && !q_full_i;
        q_push_o   = accept && !code_ge;
      end
      FrReduce: begin
        q_push_o = 1'b0;
      end
      FrPush: begin
        q_push_o = !q_full_i;
        q_data_o = '{code: rem_q[CodeW-1:0], err: 1'b1};
      end
      default: q_push_o = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == FrReduce) begin
        cnt_q <= cnt_q + RedCntW'(1);
      end else begin
        cnt_q <= '0;
      end
    end
  end

  // reduction datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      code_q <= code_i;
      rem_q  <= '0;
    end else if (state_q == FrReduce) begin
      code_q <= {code_q[CodeW-2:0], 1'b0};
      rem_q  <= rem_d;
    end
  end

endmodule

>>> rtl/rde_queue.sv
module rde_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rde_pkg::work_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output rde_pkg::work_t data_o
);
  import rde_pkg::*;

  work_t [QueueDepth-1:0] mem_q;
  logic [QPtrW-1:0]       wr_ptr_q;
  logic [QPtrW-1:0]       rd_ptr_q;
  logic [QCntW-1:0]       cnt_q;

  function automatic logic [QPtrW-1:0] ptr_next(input logic [QPtrW-1:0] ptr);
    if (ptr == QPtrW'(QueueDepth - 1)) begin
      return '0;
    end
    return ptr + QPtrW'(1);
  endfunction

  assign full_o  = cnt_q == QCntW'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  // word storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/rde_back.sv
module rde_back (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        q_valid_i,
  input  rde_pkg::work_t                              q_data_i,
  output logic                                        q_pop_o,
  input  rde_pkg::pow_entry_t [rde_pkg::MaxDigits-1:0] pow_tab_i,
  input  rde_pkg::pwr_stat_t                          stat_i,
  input  logic                                        out_ready_i,
  output logic                                        out_valid_o,
  output logic [rde_pkg::DigitW-1:0]                  digit_value_o,
  output logic [rde_pkg::PosW-1:0]                    digit_position_o,
  output logic                                        last_digit_o,
  output logic                                        range_error_o
);
  import rde_pkg::*;

  back_state_e       state_q;
  back_state_e       state_d;
  logic [CodeW-1:0]  rem_q;
  logic              err_q;
  logic [IdxW-1:0]   pos_q;
  logic [1:0]        hi_q;
  logic [IdxW-1:0]   pidx;
  pow_entry_t        ent;
  logic [RemW-1:0]   m1;
  logic [RemW-1:0]   m2;
  logic [RemW-1:0]   m3;
  logic [RemW-1:0]   rem_ext;
  logic [RemW-1:0]   sub;
  logic [RemW-1:0]   diff;
  logic [1:0]        qd;
  logic              out_free;
  logic              emit;
  logic              is_last;
  logic              out_valid_q;
  logic [DigitW-1:0] out_digit_q;
  logic [PosW-1:0]   out_pos_q;
  logic              out_last_q;
  logic              out_err_q;

  // place power for the current digit
  assign pidx    = stat_i.last_idx - pos_q;
  assign ent     = pow_tab_i[pidx];
  assign is_last = pos_q == stat_i.last_idx;

  // multiples of the place power: upper two digit bits, then lower two
  always_comb begin
    if (state_q == BkHigh) begin
      m1 = RemW'({ent.pw, 2'b00});
      m2 = RemW'({ent.pw, 3'b000});
      m3 = RemW'({ent.trip, 2'b00});
    end else begin
      m1 = RemW'(ent.pw);
      m2 = RemW'({ent.pw, 1'b0});
      m3 = RemW'(ent.trip);
    end
  end

  // pick the largest multiple that fits and take it off
  always_comb begin
    rem_ext = RemW'(rem_q);
    if (rem_ext >= m3) begin
      qd  = 2'd3;
      sub = m3;
    end else if (rem_ext >= m2) begin
      qd  = 2'd2;
      sub = m2;
    end else if (rem_ext >= m1) begin
      qd  = 2'd1;
      sub = m1;
    end else begin
      qd  = 2'd0;
      sub = '0;
    end
    diff = rem_ext - sub;
  end

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BkIdle: begin
        if (q_valid_i) begin
          state_d = BkHigh;
        end
      end
      BkHigh: begin
        state_d = BkLow;
      end
      BkLow: begin
        if (out_free) begin
          state_d = is_last ? BkIdle : BkHigh;
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  // outputs
  always_comb begin
    q_pop_o = 1'b0;
    emit    = 1'b0;
    unique case (state_q)
      BkIdle:  q_pop_o = q_valid_i;
      BkHigh:  emit    = 1'b0;
      BkLow:   emit    = out_free;
      default: emit    = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // digit datapath and output register
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      rem_q <= q_data_i.code;
      err_q <= q_data_i.err;
      pos_q <= '0;
    end else if (state_q == BkHigh) begin
      rem_q <= diff[CodeW-1:0];
      hi_q  <= qd;
    end else if (emit) begin
      rem_q <= diff[CodeW-1:0];
      pos_q <= pos_q + IdxW'(1);
    end
    if (emit) begin
      out_digit_q <= {hi_q, qd};
      out_pos_q   <= PosW'(pos_q);
      out_last_q  <= is_last;
      out_err_q   <= err_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign digit_value_o    = out_digit_q;
  assign digit_position_o = out_pos_q;
  assign last_digit_o     = out_last_q;
  assign range_error_o    = out_err_q;

endmodule

>>> rtl/radix_digit_expander.sv
// channel   direction  handshake                  payload
// input     in         in_valid_i / in_ready_o    code_value_i
// output    out        out_valid_o / out_ready_i  digit_value_o, digit_position_o,
//                                                 last_digit_o, range_error_o
// config    in         cfg_we_i                   cfg_index_i, cfg_data_i
//
// a code yields digit_count digits, each by a high and then a low radix-4 compare and
// subtract against the place power, after a load from the queue
// a code at or above base^count first runs the remainder loop in the front,
// which overlaps digit output of the previous word through the two-word queue
// after reset, and after each register write, the power table is rebuilt and
// in_ready_o stays low meanwhile
// a stalled output holds the back only; the front keeps accepting until the queue fills
`include "radix_digit_expander_assert.svh"

module radix_digit_expander (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [rde_pkg::CodeW-1:0]   code_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rde_pkg::DigitW-1:0]  digit_value_o,
  output logic [rde_pkg::PosW-1:0]    digit_position_o,
  output logic                        last_digit_o,
  output logic                        range_error_o,
  input  logic                        cfg_we_i,
  input  logic [rde_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rde_pkg::CfgW-1:0]    cfg_data_i
);
  import rde_pkg::*;

  pow_entry_t [MaxDigits-1:0] pow_tab;
  pwr_stat_t                  pwr_stat;
  logic                       q_push;
  logic                       q_full;
  logic                       q_pop;
  logic                       q_valid;
  work_t                      q_wdata;
  work_t                      q_rdata;

  // registers and place power table
  rde_power u_power (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pow_tab_o   (pow_tab),
    .stat_o      (pwr_stat)
  );

  // accept, range check and reduction
  rde_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .code_i     (code_value_i),
    .stat_i     (pwr_stat),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  // decoupling queue
  rde_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  // digit extraction and output register
  rde_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_data_i         (q_rdata),
    .q_pop_o          (q_pop),
    .pow_tab_i        (pow_tab),
    .stat_i           (pwr_stat),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .digit_value_o    (digit_value_o),
    .digit_position_o (digit_position_o),
    .last_digit_o     (last_digit_o),
    .range_error_o    (range_error_o)
  );

  // structural checks
  `RDE_ASSERT_IMP(a_ready_needs_table, in_ready_o, pwr_stat.ready, "input taken before table built")
  `RDE_ASSERT_IMP(a_no_push_when_full, q_push, !q_full, "queue written while full")
  `RDE_ASSERT_IMP(a_no_pop_when_empty, q_pop, q_valid, "queue read while empty")

endmodule

>>> tb/sv/radix_digit_expander_test.sv
`timescale 1ns / 1ps

module radix_digit_expander_test;
  import rde_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int LongHold     = 300;
  localparam int SettleCycles = 2 * MaxDigits + CodeW + 40;
  localparam int PhaseCount   = 9;
  localparam int PhaseWords   = 20;

  localparam logic [CodeW-1:0]   CodeMax        = {CodeW{1'b1}};
  localparam logic [CfgIdxW-1:0] RegFirstUnused = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegLastUnused  = {CfgIdxW{1'b1}};

  // one row of the directed plan
  typedef enum logic {
    RowWrite,
    RowCode
  } row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgW-1:0]     reg_val;
    logic [CodeW-1:0]    code;
    logic [4:0]          ndig;    // 0: digits come from the predictor
    logic [DigitW-1:0]   digit;   // every digit of the word equals this
    logic                err;
  } plan_row_t;

  // one digit word on the output channel
  typedef struct packed {
    logic [DigitW-1:0] value;
    logic [PosW-1:0]   pos;
    logic              last;
    logic              err;
  } digit_t;

  localparam int PlanRows = 32;
  localparam plan_row_t Plan [PlanRows] = '{
    // reset setting: base 2, sixteen digits
    '{RowCode,  RegDigitBase,  5'd0,  63'd0,                  5'd16, 4'd0,  1'b0},
    '{RowCode,  RegDigitBase,  5'd0,  63'hFFFF,               5'd16, 4'd1,  1'b0},
    '{RowCode,  RegDigitBase,  5'd0,  63'h10000,              5'd16, 4'd0,  1'b1},
    '{RowCode,  RegDigitBase,  5'd0,  CodeMax,                5'd16, 4'd1,  1'b1},
    '{RowCode,  RegDigitBase,  5'd0,  63'h5A5A,               5'd0,  4'd0,  1'b0},
    // base 16 over sixteen digits: combination count beyond 64 bits
    '{RowWrite, RegDigitBase,  5'd16, 63'd0,                  5'd0,  4'd0,  1'b0},
    '{RowCode,  RegDigitBase,  5'd0,  CodeMax,                5'd0,  4'd0,  1'b0},
    '{RowCode,  RegDigitBase,  5'd0,  63'd0,                  5'd16, 4'd0,  1'b0},
    // base and count below range
    '{RowWrite, RegDigitBase,  5'd1,  63'd0,                  5'd0,  4'd0,  1'b0},
    '{RowWrite, RegDigitCount, 5'd0,  63'd0,                  5'd0,  4'd0,  1'b0},
    '{RowCode,  RegDigitBase,  5'd0,  63'd1,                  5'd1,  4'd1,  1'b0},
    '{RowCode,  RegDigitBase,  5'd0,  63'd2,                  5'd1,  4'd0,  1'b1},
    // base and count above range, then base below and count above range
    '{RowWrite, RegDigitBase,  5'd31, 63'd0,                  5'd0,  4'd0,  1'b0},
    '{RowWrite, RegDigitCount, 5'd31, 63'd0,                  5'd0,  4'd0,  1'b0},
    '{RowCode,  RegDigitBase,  5'd0,  63'h0123456789ABCDEF,   5'd0,  4'd0,  1'b0},
    '{RowWrite, RegDigitBase,  5'd0,  63'd0,                  5'd0,  4'd0,  1'b0},
    '{RowWrite, RegDigitCount, 5'd17, 63'd0,                  5'd0,  4'd0,  1'b0},
    '{RowCode,  RegDigitBase,  5'd0,  63'hFFFF,               5'd16, 4'd1,  1'b0},
    // write to an unknown register leaves the setting alone
    '{RowWrite, RegFirstUnused, 5'd3, 63'd0,                  5'd0,  4'd0,  1'b0},
    '{RowCode,  RegDigitBase,  5'd0,  63'd12345,              5'd0,  4'd0,  1'b0},
    // decimal, five digits
    '{RowWrite, RegDigitBase,  5'd10, 63'd0,                  5'd0,  4'd0,  1'b0},
    '{RowWrite, RegDigitCount, 5'd5,  63'd0,                  5'd0,  4'd0,  1'b0},
    '{RowCode,  RegDigitBase,  5'd0,  63'd99999,              5'd5,  4'd9,  1'b0},
    '{RowCode,  RegDigitBase,  5'd0,  63'd100000,             5'd5,  4'd0,  1'b1},
    '{RowCode,  RegDigitBase,  5'd0,  63'd31415,              5'd0,  4'd0,  1'b0},
    // base 3, largest code in range
    '{RowWrite, RegDigitBase,  5'd3,  63'd0,                  5'd0,  4'd0,  1'b0},
    '{RowWrite, RegDigitCount, 5'd16, 63'd0,                  5'd0,  4'd0,  1'b0},
    '{RowCode,  RegDigitBase,  5'd0,  63'd43046720,           5'd16, 4'd2,  1'b0},
    // single hex digit
    '{RowWrite, RegDigitBase,  5'd16, 63'd0,                  5'd0,  4'd0,  1'b0},
    '{RowWrite, RegDigitCount, 5'd1,  63'd0,                  5'd0,  4'd0,  1'b0},
    '{RowCode,  RegDigitBase,  5'd0,  63'd15,                 5'd1,  4'd15, 1'b0},
    '{RowCode,  RegDigitBase,  5'd0,  63'd16,                 5'd1,  4'd0,  1'b1}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [CodeW-1:0]     code_value_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [DigitW-1:0]    digit_value_o;
  logic [PosW-1:0]      digit_position_o;
  logic                 last_digit_o;
  logic                 range_error_o;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CfgW-1:0]      cfg_data_i;

  // shadow of the two registers
  logic [CfgW-1:0] base_reg  = BaseReset;
  logic [CfgW-1:0] count_reg = CountReset;

  digit_t pending_digits[$];
  int     faults   = 0;
  int     cycles   = 0;
  bit     calm     = 1'b0;
  bit     hold_req = 1'b0;

  radix_digit_expander uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .code_value_i     (code_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .digit_value_o    (digit_value_o),
    .digit_position_o (digit_position_o),
    .last_digit_o     (last_digit_o),
    .range_error_o    (range_error_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // wait drawn for each input word and output digit, none in calm stretches
  function automatic int idle_draw();
    if (calm) return 0;
    return int'($urandom_range(0, 10));
  endfunction

  // base^count with clamped settings, wide enough that it never wraps
  function automatic logic [79:0] combo_count(output int radix, output int n);
    logic [79:0] total;
    int k;
    radix = (base_reg < 5'd2) ? 2 : (base_reg > CfgW'(MaxBase)) ? MaxBase : int'(base_reg);
    n = (count_reg < 5'd1) ? 1 : (count_reg > CfgW'(MaxDigits)) ? MaxDigits : int'(count_reg);
    total = 80'd1;
    for (k = 0; k < n; k++) total = total * radix;
    return total;
  endfunction

  // digits of one code, most significant first
  task automatic expand_code(input logic [CodeW-1:0] code);
    int radix;
    int n;
    int k;
    logic [79:0] total;
    logic [79:0] power;
    logic [79:0] rem;
    logic [79:0] d;
    digit_t w;
    total = combo_count(radix, n);
    rem = 80'(code);
    // a count past 64 bits is out of reach of any code, so no error there
    w.err = (rem >= total);
    if (w.err) rem = rem % total;
    power = total / radix;
    for (k = 0; k < n; k++) begin
      d = rem / power;
      rem = rem - d * power;
      w.value = d[DigitW-1:0];
      w.pos = PosW'(k);
      w.last = (k == n - 1);
      pending_digits.insert(pending_digits.size(), w);
      power = power / radix;
    end
  endtask

  // random code: mostly in range, some at the boundary, some raw noise
  function automatic logic [CodeW-1:0] pick_code();
    int radix;
    int n;
    logic [79:0] total;
    logic [79:0] raw;
    logic [79:0] v;
    total = combo_count(radix, n);
    raw = 80'({$urandom, $urandom});
    case ($urandom_range(0, 9))
      0: v = 80'(raw[CodeW-1:0]);
      1: v = total - 1;
      2: v = total;
      3: v = total + raw[9:0];
      default: v = raw % total;
    endcase
    if (v > CodeMax) v = 80'(CodeMax);
    return v[CodeW-1:0];
  endfunction

  // register write, one cycle of write enable
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegDigitBase) base_reg = val;
    else if (idx == RegDigitCount) count_reg = val;
  endtask

  // offer one code word; ndig of zero leaves the digits to the predictor
  task automatic send_code(input logic [CodeW-1:0] code, input logic [4:0] ndig,
                           input logic [DigitW-1:0] digit, input logic err);
    int gap;
    int k;
    digit_t w;
    gap = idle_draw();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    code_value_i <= code;
    do @(posedge clk_i); while (!in_ready_o);
    if (ndig == 5'd0) expand_code(code);
    else for (k = 0; k < ndig; k++) begin
      w = '{digit, PosW'(k), (k == ndig - 1), err};
      pending_digits.insert(pending_digits.size(), w);
    end
  endtask

  // drop valid and let every expected digit come out
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk_i);
  endtask

  // output side: random stalls, one long hold on request, digit checks
  initial begin
    int stall;
    digit_t got;
    digit_t want;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = idle_draw();
      if (hold_req) begin
        hold_req = 1'b0;
        stall = LongHold;
      end
      repeat (stall) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got = '{digit_value_o, digit_position_o, last_digit_o, range_error_o};
      if (pending_digits.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("digit with none expected: value %0d pos %0d last %0b err %0b",
                   got.value, got.pos, got.last, got.err);
      end else begin
        want = pending_digits.pop_front();
        if (got !== want) begin
          faults++;
          if (faults <= 10) begin
            $display("digit mismatch: expected value %0d pos %0d last %0b err %0b",
                     want.value, want.pos, want.last, want.err);
            $display("                got value %0d pos %0d last %0b err %0b",
                     got.value, got.pos, got.last, got.err);
          end
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d digits outstanding", cycles, pending_digits.size());
    $display("** radix_digit_expander: FAILED **");
    $finish;
  end

  // stimulus
  initial begin
    int i;
    int ph;
    int k;
    in_valid_i   = 1'b0;
    code_value_i = '0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = RegDigitBase;
    cfg_data_i   = '0;
    rst_ni       = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed plan
    for (i = 0; i < PlanRows; i++) begin
      if (Plan[i].kind == RowWrite) begin
        wait_idle();
        write_reg(Plan[i].reg_idx, Plan[i].reg_val);
      end else begin
        send_code(Plan[i].code, Plan[i].ndig, Plan[i].digit, Plan[i].err);
      end
    end

    // random phases, extreme settings first
    for (ph = 0; ph < PhaseCount; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          write_reg(RegDigitBase, CfgW'(MaxBase));
          write_reg(RegDigitCount, CfgW'(MaxDigits));
        end
        1: begin
          write_reg(RegDigitBase, CfgW'(2));
          write_reg(RegDigitCount, CfgW'(1));
        end
        2: write_reg(RegDigitCount, CfgW'(MaxDigits));
        3: begin
          write_reg(RegDigitBase, CfgW'(MaxBase));
          write_reg(RegDigitCount, CfgW'(1));
        end
        default: begin
          if ($urandom_range(0, 2) == 0)
            write_reg(CfgIdxW'($urandom_range(RegFirstUnused, RegLastUnused)),
                      CfgW'($urandom));
          write_reg(RegDigitCount, CfgW'($urandom));
          write_reg(RegDigitBase, CfgW'($urandom));
        end
      endcase
      calm = (ph == 4);
      for (k = 0; k < PhaseWords; k++) begin
        // long output hold while input keeps coming
        if (ph == 6 && k == 3) hold_req = 1'b1;
        send_code(pick_code(), 5'd0, '0, 1'b0);
      end
    end
    calm = 1'b0;

    wait_idle();
    repeat (SettleCycles) @(posedge clk_i);
    if (faults == 0) $display("** radix_digit_expander: PASSED **");
    else $display("** radix_digit_expander: FAILED **");
    $finish;
  end

endmodule
